/* hdl/sct_pkg.sv */
package sct_pkg;

  typedef enum logic [3:0] {
    M_LEAD      = 4'd0,
    M_GAP       = 4'd1,
    M_ARG       = 4'd2,
    M_OUT_FIRST = 4'd3,
    M_WAIT_IN   = 4'd4,
    M_WAIT_OUT  = 4'd5,
    M_WAIT_ERR  = 4'd6,
    M_FILE_IN   = 4'd7,
    M_FILE_OUT  = 4'd8,
    M_FILE_ERR  = 4'd9,
    M_FROZEN    = 4'd10
  } mode_t;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_WS,
    PH_FAIL6,
    PH_RUN_H2,
    PH_RUN_MAIN,
    PH_CHR_H2,
    PH_CHR_MAIN,
    PH_FIN_H2,
    PH_FIN_TOK,
    PH_FIN_END
  } phase_t;

  localparam logic [1:0] REC_CHAR = 2'd0;
  localparam logic [1:0] REC_TOK  = 2'd1;
  localparam logic [1:0] REC_CMD  = 2'd2;

  localparam logic [1:0] KIND_ARG = 2'd0;
  localparam logic [1:0] KIND_IN  = 2'd1;
  localparam logic [1:0] KIND_OUT = 2'd2;
  localparam logic [1:0] KIND_ERR = 2'd3;

  localparam logic [1:0] Q_NONE   = 2'd0;
  localparam logic [1:0] Q_DOUBLE = 2'd1;
  localparam logic [1:0] Q_SINGLE = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_MISS_IN  = 3'd2;
  localparam logic [2:0] ST_MISS_OUT = 3'd3;
  localparam logic [2:0] ST_MISS_ERR = 3'd4;
  localparam logic [2:0] ST_MANY     = 3'd5;
  localparam logic [2:0] ST_OVF      = 3'd6;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       ws;
  } item_t;

  typedef struct packed {
    mode_t      mode;
    logic [1:0] quote;
    logic       held2;
    logic       app;
    logic [2:0] err;
  } core_t;

  typedef struct packed {
    logic [1:0] rtype;
    logic [7:0] ch;
    logic [1:0] kind;
    logic       app;
    logic [2:0] st;
    logic [6:0] tot;
  } rec_t;

endpackage

/* hdl/sct_front.sv */
module sct_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         ch,
  input  logic               last_char,
  output logic               q_valid,
  output sct_pkg::item_t     q_item,
  input  logic               q_pop
);

  sct_pkg::item_t slots [2];
  logic           head;
  logic [1:0]     count;
  logic           push;
  logic           tail;

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slots[head];
  assign tail     = head ^ count[0];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[tail].ch   <= ch;
      slots[tail].last <= last_char;
      slots[tail].ws   <= (ch == sct_pkg::CH_SPACE) || (ch == sct_pkg::CH_TAB) ||
                          (ch == sct_pkg::CH_NL);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (q_pop && q_valid) head <= ~head;
      count <= count + 2'(push) - 2'(q_pop && q_valid);
    end
  end

endmodule

/* hdl/sct_back.sv */
module sct_back #(
  parameter int MAX_TOKEN_LEN = 1024,
  parameter int MAX_ARG_COUNT = 64,
  parameter int RUN_DEPTH     = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  sct_pkg::item_t q_item,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output sct_pkg::rec_t  out_rec
);

  localparam int TW = $clog2(MAX_TOKEN_LEN);
  localparam int AW = $clog2(MAX_ARG_COUNT + 1);
  localparam int RA = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;
  localparam int CW = $clog2(RUN_DEPTH + 2);

  sct_pkg::phase_t phase, phase_next;
  sct_pkg::core_t  core, core_next;
  logic [TW-1:0]   tlen, tlen_next;
  logic [AW-1:0]   argc, argc_next;
  logic [CW-1:0]   rc, rc_next;
  logic [RA-1:0]   idx, idx_next;
  sct_pkg::item_t  cur;
  logic [7:0]      run [RUN_DEPTH];
  logic [7:0]      rd_data;
  logic            out_free, act, commit, em, need_main, run_last, wr_en;
  sct_pkg::rec_t   rec;
  logic [7:0]      b;

  function automatic logic [1:0] kind_of(input sct_pkg::mode_t m);
    logic [1:0] k;
    unique case (m)
      sct_pkg::M_FILE_IN, sct_pkg::M_WAIT_IN:   k = sct_pkg::KIND_IN;
      sct_pkg::M_FILE_OUT, sct_pkg::M_WAIT_OUT: k = sct_pkg::KIND_OUT;
      sct_pkg::M_FILE_ERR, sct_pkg::M_WAIT_ERR: k = sct_pkg::KIND_ERR;
      default:                                  k = sct_pkg::KIND_ARG;
    endcase
    return k;
  endfunction

  function automatic logic in_token(input sct_pkg::mode_t m);
    return (m == sct_pkg::M_ARG) || (m == sct_pkg::M_FILE_IN) ||
           (m == sct_pkg::M_FILE_OUT) || (m == sct_pkg::M_FILE_ERR);
  endfunction

  function automatic void tok_char(input logic [7:0] c, input logic [1:0] k,
                                   inout logic [TW-1:0] tl, inout logic e,
                                   inout sct_pkg::rec_t r);
    if (tl < TW'(MAX_TOKEN_LEN - 1)) begin
      e = 1'b1;
      r = '{rtype: sct_pkg::REC_CHAR, ch: c, kind: k, app: 1'b0,
            st: sct_pkg::ST_OK, tot: 7'd0};
      tl = tl + TW'(1);
    end
  endfunction

  function automatic void tok_end(input sct_pkg::mode_t m, inout logic e,
                                  inout sct_pkg::rec_t r);
    e = 1'b1;
    r = '{rtype: sct_pkg::REC_TOK, ch: 8'd0, kind: kind_of(m), app: 1'b0,
          st: sct_pkg::ST_OK, tot: 7'd0};
  endfunction

  function automatic void arg_char(input logic [7:0] c, inout sct_pkg::core_t s,
                                   inout logic [TW-1:0] tl, inout logic [AW-1:0] ac,
                                   inout logic e, inout sct_pkg::rec_t r);
    if (s.mode == sct_pkg::M_GAP) begin
      if (ac >= AW'(MAX_ARG_COUNT)) begin
        s.err   = sct_pkg::ST_MANY;
        s.mode  = sct_pkg::M_FROZEN;
        s.held2 = 1'b0;
      end else begin
        ac      = ac + AW'(1);
        s.mode  = sct_pkg::M_ARG;
        s.quote = sct_pkg::Q_NONE;
        tl      = '0;
      end
    end
    if (s.mode == sct_pkg::M_ARG) begin
      if (s.quote == sct_pkg::Q_NONE && (c == sct_pkg::CH_DQ || c == sct_pkg::CH_SQ))
        s.quote = (c == sct_pkg::CH_DQ) ? sct_pkg::Q_DOUBLE : sct_pkg::Q_SINGLE;
      else
        tok_char(c, sct_pkg::KIND_ARG, tl, e, r);
    end
  endfunction

  function automatic void main_step(input logic [7:0] c, inout sct_pkg::core_t s,
                                    inout logic [TW-1:0] tl, inout logic [AW-1:0] ac,
                                    inout logic e, inout sct_pkg::rec_t r);
    sct_pkg::mode_t m;
    m = s.mode;
    if (m == sct_pkg::M_OUT_FIRST) begin
      s.mode = sct_pkg::M_WAIT_OUT;
      if (c == sct_pkg::CH_GT) begin
        s.app = 1'b1;
        return;
      end
      m = sct_pkg::M_WAIT_OUT;
    end
    unique case (m)
      sct_pkg::M_GAP, sct_pkg::M_ARG: begin
        if (m == sct_pkg::M_ARG && s.quote != sct_pkg::Q_NONE) begin
          if ((s.quote == sct_pkg::Q_DOUBLE && c == sct_pkg::CH_DQ) ||
              (s.quote == sct_pkg::Q_SINGLE && c == sct_pkg::CH_SQ))
            s.quote = sct_pkg::Q_NONE;
          else
            tok_char(c, sct_pkg::KIND_ARG, tl, e, r);
        end else if (c == sct_pkg::CH_SPACE || c == sct_pkg::CH_LT || c == sct_pkg::CH_GT) begin
          if (m == sct_pkg::M_ARG) tok_end(m, e, r);
          s.mode = (c == sct_pkg::CH_SPACE) ? sct_pkg::M_GAP :
                   (c == sct_pkg::CH_LT) ? sct_pkg::M_WAIT_IN : sct_pkg::M_OUT_FIRST;
        end else if (c == sct_pkg::CH_TWO) begin
          s.held2 = 1'b1;
        end else begin
          arg_char(c, s, tl, ac, e, r);
        end
      end
      sct_pkg::M_WAIT_IN, sct_pkg::M_WAIT_OUT, sct_pkg::M_WAIT_ERR: begin
        if (c != sct_pkg::CH_SPACE) begin
          s.mode = (m == sct_pkg::M_WAIT_IN) ? sct_pkg::M_FILE_IN :
                   (m == sct_pkg::M_WAIT_OUT) ? sct_pkg::M_FILE_OUT : sct_pkg::M_FILE_ERR;
          tl = '0;
          tok_char(c, kind_of(s.mode), tl, e, r);
        end
      end
      sct_pkg::M_FILE_IN, sct_pkg::M_FILE_OUT, sct_pkg::M_FILE_ERR: begin
        if (c == sct_pkg::CH_SPACE) begin
          tok_end(m, e, r);
          s.mode = sct_pkg::M_GAP;
        end else begin
          tok_char(c, kind_of(m), tl, e, r);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void h2_step(input logic [7:0] c, inout sct_pkg::core_t s,
                                  inout logic [TW-1:0] tl, inout logic [AW-1:0] ac,
                                  inout logic e, inout sct_pkg::rec_t r,
                                  output logic more);
    more = 1'b0;
    if (s.mode == sct_pkg::M_FROZEN) begin
      more = 1'b0;
    end else if (s.held2) begin
      s.held2 = 1'b0;
      if (c == sct_pkg::CH_GT) begin
        if (s.mode == sct_pkg::M_ARG) tok_end(s.mode, e, r);
        s.mode = sct_pkg::M_WAIT_ERR;
      end else begin
        arg_char(sct_pkg::CH_TWO, s, tl, ac, e, r);
        more = (s.mode != sct_pkg::M_FROZEN);
      end
    end else begin
      main_step(c, s, tl, ac, e, r);
    end
  endfunction

  assign out_free = !out_valid || out_ready;
  assign act      = (phase != sct_pkg::PH_IDLE) && out_free;
  assign q_pop    = (phase == sct_pkg::PH_IDLE) && q_valid;
  assign commit   = act || q_pop;
  assign b        = (phase == sct_pkg::PH_RUN_H2 || phase == sct_pkg::PH_RUN_MAIN) ?
                    rd_data : cur.ch;

  always_comb begin
    core_next = core;
    tlen_next = tlen;
    argc_next = argc;
    rc_next   = rc;
    idx_next  = idx;
    em        = 1'b0;
    rec       = '0;
    need_main = 1'b0;
    run_last  = 1'b0;
    wr_en     = 1'b0;
    unique case (phase)
      sct_pkg::PH_IDLE: begin
        idx_next = '0;
        if (q_valid && !q_item.ws && core.mode == sct_pkg::M_LEAD)
          core_next.mode = sct_pkg::M_GAP;
      end
      sct_pkg::PH_WS: begin
        if (core.mode != sct_pkg::M_FROZEN && core.mode != sct_pkg::M_LEAD) begin
          if (core.held2) begin
            core_next.held2 = 1'b0;
            arg_char(sct_pkg::CH_TWO, core_next, tlen_next, argc_next, em, rec);
          end
          if (core_next.mode != sct_pkg::M_FROZEN) begin
            if (rc < CW'(RUN_DEPTH)) begin
              wr_en   = 1'b1;
              rc_next = rc + CW'(1);
            end else begin
              rc_next = CW'(RUN_DEPTH + 1);
            end
          end
        end
      end
      sct_pkg::PH_FAIL6: begin
        if (in_token(core.mode)) tok_end(core.mode, em, rec);
        core_next.err   = sct_pkg::ST_OVF;
        core_next.mode  = sct_pkg::M_FROZEN;
        core_next.held2 = 1'b0;
      end
      sct_pkg::PH_RUN_H2, sct_pkg::PH_CHR_H2:
        h2_step(b, core_next, tlen_next, argc_next, em, rec, need_main);
      sct_pkg::PH_RUN_MAIN, sct_pkg::PH_CHR_MAIN:
        main_step(b, core_next, tlen_next, argc_next, em, rec);
      sct_pkg::PH_FIN_H2: begin
        if (core.mode != sct_pkg::M_FROZEN && core.held2) begin
          core_next.held2 = 1'b0;
          arg_char(sct_pkg::CH_TWO, core_next, tlen_next, argc_next, em, rec);
        end
      end
      sct_pkg::PH_FIN_TOK: begin
        if (in_token(core.mode)) tok_end(core.mode, em, rec);
      end
      sct_pkg::PH_FIN_END: begin
        em        = 1'b1;
        rec.rtype = sct_pkg::REC_CMD;
        rec.app   = core.app;
        rec.tot   = 7'(argc);
        unique case (core.mode)
          sct_pkg::M_FROZEN:                          rec.st = core.err;
          sct_pkg::M_LEAD:                            rec.st = sct_pkg::ST_EMPTY;
          sct_pkg::M_WAIT_IN:                         rec.st = sct_pkg::ST_MISS_IN;
          sct_pkg::M_OUT_FIRST, sct_pkg::M_WAIT_OUT:  rec.st = sct_pkg::ST_MISS_OUT;
          sct_pkg::M_WAIT_ERR:                        rec.st = sct_pkg::ST_MISS_ERR;
          default:                                    rec.st = sct_pkg::ST_OK;
        endcase
        core_next = '{mode: sct_pkg::M_LEAD, quote: sct_pkg::Q_NONE, held2: 1'b0,
                      app: 1'b0, err: sct_pkg::ST_OK};
        tlen_next = '0;
        argc_next = '0;
        rc_next   = '0;
      end
      default: ;
    endcase
    if (phase == sct_pkg::PH_RUN_H2 || phase == sct_pkg::PH_RUN_MAIN) begin
      run_last = (core_next.mode == sct_pkg::M_FROZEN) || ((CW'(idx) + CW'(1)) == rc);
      if (!need_main) begin
        if (run_last) rc_next = '0;
        else          idx_next = idx + RA'(1);
      end
    end
    if (core_next.mode == sct_pkg::M_FROZEN) rc_next = '0;
  end

  always_comb begin
    phase_next = phase;
    unique case (phase)
      sct_pkg::PH_IDLE: begin
        if (q_valid) begin
          if (core.mode == sct_pkg::M_FROZEN)
            phase_next = q_item.last ? sct_pkg::PH_FIN_H2 : sct_pkg::PH_IDLE;
          else if (q_item.ws)            phase_next = sct_pkg::PH_WS;
          else if (rc > CW'(RUN_DEPTH))  phase_next = sct_pkg::PH_FAIL6;
          else if (rc != '0)             phase_next = sct_pkg::PH_RUN_H2;
          else                           phase_next = sct_pkg::PH_CHR_H2;
        end
      end
      sct_pkg::PH_WS, sct_pkg::PH_FAIL6, sct_pkg::PH_CHR_MAIN:
        if (out_free) phase_next = cur.last ? sct_pkg::PH_FIN_H2 : sct_pkg::PH_IDLE;
      sct_pkg::PH_RUN_H2:
        if (out_free)
          phase_next = need_main ? sct_pkg::PH_RUN_MAIN :
                       run_last ? sct_pkg::PH_CHR_H2 : sct_pkg::PH_RUN_H2;
      sct_pkg::PH_RUN_MAIN:
        if (out_free) phase_next = run_last ? sct_pkg::PH_CHR_H2 : sct_pkg::PH_RUN_H2;
      sct_pkg::PH_CHR_H2:
        if (out_free)
          phase_next = need_main ? sct_pkg::PH_CHR_MAIN :
                       cur.last ? sct_pkg::PH_FIN_H2 : sct_pkg::PH_IDLE;
      sct_pkg::PH_FIN_H2:  if (out_free) phase_next = sct_pkg::PH_FIN_TOK;
      sct_pkg::PH_FIN_TOK: if (out_free) phase_next = sct_pkg::PH_FIN_END;
      sct_pkg::PH_FIN_END: if (out_free) phase_next = sct_pkg::PH_IDLE;
      default: phase_next = sct_pkg::PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en && act) run[rc[RA-1:0]] <= cur.ch;
    rd_data <= run[commit ? idx_next : idx];
    if (q_pop) cur <= q_item;
    if (act && em) out_rec <= rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= sct_pkg::PH_IDLE;
      core      <= '{mode: sct_pkg::M_LEAD, quote: sct_pkg::Q_NONE, held2: 1'b0,
                     app: 1'b0, err: sct_pkg::ST_OK};
      tlen      <= '0;
      argc      <= '0;
      rc        <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (commit) begin
        core <= core_next;
        tlen <= tlen_next;
        argc <= argc_next;
        rc   <= rc_next;
        idx  <= idx_next;
      end
      if (act && em)      out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

/* hdl/shell_command_tokenizer.sv */
// Command-line tokenizer: one byte beat in, token-character, token-end and command-end
// beats out. A two-entry queue splits the input stage from the parse sequencer, which does
// one parse step per cycle with one result beat at most. A plain byte takes a pop step and
// an H2 step, plus a main step when it releases a held 2; held whitespace bytes are first
// replayed from the run memory the same way; a byte on a line in error is only popped; the
// final byte adds the closing-record steps. Output stalls hold the sequencer.
module shell_command_tokenizer #(
  parameter int MAX_TOKEN_LEN = 1024,
  parameter int MAX_ARG_COUNT = 64,
  parameter int RUN_DEPTH     = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] ch,
  input  logic       last_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] rec_type,
  output logic [7:0] char_out,
  output logic [1:0] token_kind,
  output logic       append_flag,
  output logic [2:0] status,
  output logic [6:0] arg_total
);

  logic           q_valid;
  logic           q_pop;
  sct_pkg::item_t q_item;
  sct_pkg::rec_t  out_rec;

  sct_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .ch        (ch),
    .last_char (last_char),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  sct_back #(
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
    .MAX_ARG_COUNT (MAX_ARG_COUNT),
    .RUN_DEPTH     (RUN_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rec   (out_rec)
  );

  assign rec_type    = out_rec.rtype;
  assign char_out    = out_rec.ch;
  assign token_kind  = out_rec.kind;
  assign append_flag = out_rec.app;
  assign status      = out_rec.st;
  assign arg_total   = out_rec.tot;

endmodule

/* hdl/sct_checker.sv */
module sct_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] rec_type,
  input logic [7:0] char_out,
  input logic [1:0] token_kind,
  input logic       append_flag,
  input logic [2:0] status,
  input logic [6:0] arg_total
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(rec_type) && $stable(char_out))
    else $error("stalled output beat changed");

  a_type: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> rec_type != 2'd3)
    else $error("bad record type");

  a_char: assert property (@(posedge clk) disable iff (rst)
    out_valid && rec_type != sct_pkg::REC_CHAR |-> char_out == 8'd0)
    else $error("char_out set on non-character beat");

  a_tail: assert property (@(posedge clk) disable iff (rst)
    out_valid && rec_type != sct_pkg::REC_CMD |->
      status == sct_pkg::ST_OK && !append_flag && arg_total == 7'd0)
    else $error("command fields set on token beat");

  a_cmd: assert property (@(posedge clk) disable iff (rst)
    out_valid && rec_type == sct_pkg::REC_CMD |-> token_kind == sct_pkg::KIND_ARG &&
      status != 3'd7)
    else $error("bad command end beat");

endmodule

bind shell_command_tokenizer sct_checker u_sct_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .rec_type    (rec_type),
  .char_out    (char_out),
  .token_kind  (token_kind),
  .append_flag (append_flag),
  .status      (status),
  .arg_total   (arg_total)
);

/* tb/tb_shell_command_tokenizer.sv */
module tb_shell_command_tokenizer;

  localparam int TOK_MAX = 1024;
  localparam int ARG_MAX = 64;
  localparam int RUNS    = 16;
  localparam int LIMIT   = 400000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] ch = '0;
  logic       last_char = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] rec_type;
  logic [7:0] char_out;
  logic [1:0] token_kind;
  logic       append_flag;
  logic [2:0] status;
  logic [6:0] arg_total;

  always #6 clk = ~clk;

  shell_command_tokenizer u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .ch(ch), .last_char(last_char),
    .out_valid(out_valid), .out_ready(out_ready),
    .rec_type(rec_type), .char_out(char_out), .token_kind(token_kind),
    .append_flag(append_flag), .status(status), .arg_total(arg_total)
  );

  // tokenizer state mirror
  sct_pkg::mode_t p_mode;
  logic [1:0]     p_quote;
  logic           p_held2;
  int             p_len;
  int             p_args;
  logic           p_app;
  logic [2:0]     p_err;
  logic [7:0]     p_run [RUNS];
  int             p_runs;

  sct_pkg::rec_t want_q[$];
  int   errors = 0;
  int   cycles = 0;
  int   beats_in = 0;
  int   beats_out = 0;
  int   lines = 0;

  function automatic sct_pkg::rec_t mk(logic [1:0] t, logic [7:0] c, logic [1:0] k,
                                       logic a, logic [2:0] s, logic [6:0] n);
    sct_pkg::rec_t r;
    r.rtype = t; r.ch = c; r.kind = k; r.app = a; r.st = s; r.tot = n;
    return r;
  endfunction

  function automatic logic [1:0] kind_of(sct_pkg::mode_t m);
    return (m == sct_pkg::M_ARG) ? sct_pkg::KIND_ARG : 2'(int'(m) - 6);
  endfunction

  task automatic close_token();
    want_q.push_back(mk(sct_pkg::REC_TOK, 8'h00, kind_of(p_mode), 1'b0, sct_pkg::ST_OK,
                        7'd0));
  endtask

  task automatic token_byte(logic [7:0] c, logic [1:0] k);
    if (p_len < TOK_MAX - 1) begin
      want_q.push_back(mk(sct_pkg::REC_CHAR, c, k, 1'b0, sct_pkg::ST_OK, 7'd0));
      p_len++;
    end
  endtask

  task automatic abort_line(logic [2:0] code);
    if (p_mode == sct_pkg::M_ARG ||
        (p_mode >= sct_pkg::M_FILE_IN && p_mode <= sct_pkg::M_FILE_ERR)) close_token();
    p_err = code;
    p_mode = sct_pkg::M_FROZEN;
    p_held2 = 1'b0;
    p_runs = 0;
  endtask

  task automatic plain_byte(logic [7:0] c);
    if (p_mode == sct_pkg::M_GAP) begin
      if (p_args >= ARG_MAX) begin
        abort_line(sct_pkg::ST_MANY);
        return;
      end
      p_args++;
      p_mode = sct_pkg::M_ARG;
      p_quote = sct_pkg::Q_NONE;
      p_len = 0;
    end
    if (p_mode != sct_pkg::M_ARG) return;
    if (p_quote == sct_pkg::Q_NONE && (c == sct_pkg::CH_DQ || c == sct_pkg::CH_SQ))
      p_quote = (c == sct_pkg::CH_DQ) ? sct_pkg::Q_DOUBLE : sct_pkg::Q_SINGLE;
    else
      token_byte(c, sct_pkg::KIND_ARG);
  endtask

  task automatic parse_byte(logic [7:0] c);
    if (p_mode == sct_pkg::M_FROZEN) return;
    if (p_held2) begin
      p_held2 = 1'b0;
      if (c == sct_pkg::CH_GT) begin
        if (p_mode == sct_pkg::M_ARG) close_token();
        p_mode = sct_pkg::M_WAIT_ERR;
        return;
      end
      plain_byte(sct_pkg::CH_TWO);
      if (p_mode == sct_pkg::M_FROZEN) return;
    end
    case (p_mode)
      sct_pkg::M_GAP, sct_pkg::M_ARG: begin
        if (p_mode == sct_pkg::M_ARG && p_quote != sct_pkg::Q_NONE) begin
          if ((p_quote == sct_pkg::Q_DOUBLE && c == sct_pkg::CH_DQ) ||
              (p_quote == sct_pkg::Q_SINGLE && c == sct_pkg::CH_SQ))
            p_quote = sct_pkg::Q_NONE;
          else
            token_byte(c, sct_pkg::KIND_ARG);
        end else if (c == sct_pkg::CH_SPACE || c == sct_pkg::CH_LT || c == sct_pkg::CH_GT) begin
          if (p_mode == sct_pkg::M_ARG) close_token();
          p_mode = (c == sct_pkg::CH_SPACE) ? sct_pkg::M_GAP :
                   (c == sct_pkg::CH_LT) ? sct_pkg::M_WAIT_IN : sct_pkg::M_OUT_FIRST;
        end else if (c == sct_pkg::CH_TWO) begin
          p_held2 = 1'b1;
        end else begin
          plain_byte(c);
        end
      end
      sct_pkg::M_OUT_FIRST, sct_pkg::M_WAIT_IN, sct_pkg::M_WAIT_OUT,
      sct_pkg::M_WAIT_ERR: begin
        if (p_mode == sct_pkg::M_OUT_FIRST) begin
          p_mode = sct_pkg::M_WAIT_OUT;
          if (c == sct_pkg::CH_GT) begin
            p_app = 1'b1;
            return;
          end
        end
        if (c != sct_pkg::CH_SPACE) begin
          p_mode = sct_pkg::mode_t'(int'(p_mode) + 3);
          p_len = 0;
          token_byte(c, kind_of(p_mode));
        end
      end
      sct_pkg::M_FILE_IN, sct_pkg::M_FILE_OUT, sct_pkg::M_FILE_ERR: begin
        if (c == sct_pkg::CH_SPACE) begin
          close_token();
          p_mode = sct_pkg::M_GAP;
        end else begin
          token_byte(c, kind_of(p_mode));
        end
      end
      default: ;
    endcase
  endtask

  task automatic clear_line();
    p_mode = sct_pkg::M_LEAD; p_quote = sct_pkg::Q_NONE; p_held2 = 1'b0; p_len = 0;
    p_args = 0; p_app = 1'b0; p_err = sct_pkg::ST_OK; p_runs = 0;
  endtask

  task automatic end_line();
    logic [2:0] st;
    st = sct_pkg::ST_OK;
    if (p_mode != sct_pkg::M_FROZEN && p_held2) begin
      p_held2 = 1'b0;
      plain_byte(sct_pkg::CH_TWO);
    end
    case (p_mode)
      sct_pkg::M_FROZEN: st = p_err;
      sct_pkg::M_LEAD: st = sct_pkg::ST_EMPTY;
      sct_pkg::M_ARG, sct_pkg::M_FILE_IN, sct_pkg::M_FILE_OUT,
      sct_pkg::M_FILE_ERR: close_token();
      sct_pkg::M_WAIT_IN: st = sct_pkg::ST_MISS_IN;
      sct_pkg::M_OUT_FIRST, sct_pkg::M_WAIT_OUT: st = sct_pkg::ST_MISS_OUT;
      sct_pkg::M_WAIT_ERR: st = sct_pkg::ST_MISS_ERR;
      default: ;
    endcase
    want_q.push_back(mk(sct_pkg::REC_CMD, 8'h00, sct_pkg::KIND_ARG, p_app, st,
                        7'(p_args)));
    clear_line();
  endtask

  task automatic predict_tokens(logic [7:0] c, logic lst);
    bit ws;
    ws = (c == sct_pkg::CH_SPACE || c == sct_pkg::CH_TAB || c == sct_pkg::CH_NL);
    if (p_mode != sct_pkg::M_FROZEN) begin
      if (ws) begin
        if (p_mode != sct_pkg::M_LEAD) begin
          if (p_held2) begin
            p_held2 = 1'b0;
            plain_byte(sct_pkg::CH_TWO);
          end
          if (p_mode != sct_pkg::M_FROZEN) begin
            if (p_runs < RUNS) p_run[p_runs++] = c;
            else p_runs = RUNS + 1;
          end
        end
      end else begin
        if (p_mode == sct_pkg::M_LEAD) p_mode = sct_pkg::M_GAP;
        if (p_runs > RUNS) begin
          abort_line(sct_pkg::ST_OVF);
        end else begin
          for (int i = 0; i < p_runs && p_mode != sct_pkg::M_FROZEN; i++)
            parse_byte(p_run[i]);
          p_runs = 0;
          parse_byte(c);
        end
      end
    end
    if (lst) begin
      end_line();
      lines++;
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout at %0t", $time);
      $display("end of test: mismatches");
      $finish;
    end
    if (!rst && out_valid && out_ready) begin
      beats_out <= beats_out + 1;
      if (want_q.size() == 0) begin
        $display("%0t: expected no beat, got type=%0d char=%0h", $time, rec_type, char_out);
        errors <= errors + 1;
      end else begin
        sct_pkg::rec_t w, g;
        w = want_q.pop_front();
        g = mk(rec_type, char_out, token_kind, append_flag, status, arg_total);
        if (g !== w) begin
          $display("%0t: expected t=%0d c=%0h k=%0d a=%0d s=%0d n=%0d,",
                   $time, w.rtype, w.ch, w.kind, w.app, w.st, w.tot);
          $display("    got t=%0d c=%0h k=%0d a=%0d s=%0d n=%0d",
                   g.rtype, g.ch, g.kind, g.app, g.st, g.tot);
          errors <= errors + 1;
        end
      end
    end
  end

  int stall_mode = 0;
  always @(negedge clk) begin
    if (cycles % 500 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ((cycles % 7) < 4);
      default: out_ready <= ($urandom_range(0, 1) != 0);
    endcase
  end

  int burst = 0;

  task automatic send(logic [7:0] c, logic lst, bit gaps);
    int gap;
    if (gaps) begin
      if (burst == 0) begin
        gap = $urandom_range(0, 4);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        burst = $urandom_range(1, 12);
      end
      burst--;
    end
    ch <= c;
    last_char <= lst;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_tokens(c, lst);
    beats_in++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (want_q.size() != 0) @(negedge clk);
  endtask

  // directed rows: byte, last flag, expected command-end status (or -1 to use predictor)
  typedef struct {
    logic [7:0] c;
    logic       lst;
    int         st;
  } row_t;

  row_t rows[$];

  task automatic add(string s, int st);
    for (int i = 0; i < s.len(); i++) begin
      row_t r;
      r.c = s[i]; r.lst = (i == s.len() - 1); r.st = r.lst ? st : -1;
      rows.push_back(r);
    end
  endtask

  function automatic logic [7:0] rand_byte();
    int k;
    k = $urandom_range(0, 19);
    case (k)
      0, 1, 2, 3: return sct_pkg::CH_SPACE;
      4: return sct_pkg::CH_TAB;
      5: return sct_pkg::CH_NL;
      6: return sct_pkg::CH_TWO;
      7, 8: return sct_pkg::CH_GT;
      9: return sct_pkg::CH_LT;
      10: return sct_pkg::CH_DQ;
      11: return sct_pkg::CH_SQ;
      12: return 8'h00;
      13: return 8'hFF;
      14: return 8'($urandom_range(128, 255));
      default: return 8'($urandom_range(8'h61, 8'h7A));
    endcase
  endfunction

  initial begin
    clear_line();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    add(" \t ", sct_pkg::ST_EMPTY);
    add("a", sct_pkg::ST_OK);
    add("<", sct_pkg::ST_MISS_IN);
    add(">>", sct_pkg::ST_MISS_OUT);
    add("x 2>", sct_pkg::ST_MISS_ERR);
    add("\"a b\"c2 >f", sct_pkg::ST_OK);
    for (int i = 0; i < rows.size(); i++) begin
      send(rows[i].c, rows[i].lst, 1'b0);
      if (rows[i].lst && rows[i].st >= 0 && want_q.size() != 0 &&
          want_q[$].st !== 3'(rows[i].st)) begin
        $display("%0t: directed status expected %0d, predicted %0d",
                 $time, rows[i].st, want_q[$].st);
        errors++;
      end
    end
    drain();

    // run overflow, extreme bytes, too many args
    send(8'h00, 1'b0, 1'b0);
    repeat (RUNS + 1) send(sct_pkg::CH_SPACE, 1'b0, 1'b0);
    send(8'hFF, 1'b1, 1'b0);
    for (int i = 0; i < ARG_MAX + 1; i++) begin
      send(8'h61, 1'b0, 1'b1);
      send(sct_pkg::CH_SPACE, 1'b0, 1'b1);
    end
    send(8'h62, 1'b1, 1'b1);
    drain();

    for (int n = 0; n < 110; ) begin
      int len;
      len = $urandom_range(1, 20);
      for (int i = 0; i < len; i++) begin
        logic [7:0] c;
        c = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : rand_byte();
        send(c, i == len - 1, 1'b1);
        n++;
      end
      if ($urandom_range(0, 9) == 0) drain();
    end

    drain();
    repeat (60) @(negedge clk);
    $display("covered %0d input beats, %0d output beats, %0d command lines",
             beats_in, beats_out, lines);
    if (errors == 0 && want_q.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

/* files.f */
hdl/sct_pkg.sv
hdl/sct_front.sv
hdl/sct_back.sv
hdl/shell_command_tokenizer.sv
hdl/sct_checker.sv
tb/tb_shell_command_tokenizer.sv
